>>> hw/rtl/ksel_pkg.sv
// Shared types and constants for the k-smallest selection block.
// Used by every module under hw/rtl; depends on nothing.
package ksel_pkg;

  localparam int MAX_SELECT_DEF = 64;
  localparam int VALUE_BITS_DEF = 32;

  // select count register
  localparam int             SEL_W     = 7;
  localparam logic [SEL_W-1:0] SEL_RESET = 7'd4;

  localparam int RANK_W = 6;

  // one input transfer
  typedef struct packed {
    logic signed [31:0] sample;
    logic               final_item;
  } in_item_t;

  // one result transfer
  typedef struct packed {
    logic signed [31:0]  picked_value;
    logic [RANK_W-1:0]   rank;
    logic                end_of_run;
  } out_item_t;

  // per-cell control, broadcast along the chain
  typedef struct packed {
    logic ins;     // take in a new sample this cycle
    logic pop;     // shift toward cell 0 this cycle
    logic active;  // cell index is below the effective select count
  } cell_ctl_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_COLLECT = 2'b01,
    ST_DRAIN   = 2'b10
  } state_t;

endpackage

>>> hw/rtl/ksel_cell.sv
// One cell of the sorted chain: holds one kept value and its valid flag.
// Depends on ksel_pkg for the cell control struct.
module ksel_cell
  import ksel_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cell_ctl_t                    ctl,
  input  logic signed [VALUE_BITS-1:0] sample,
  input  logic                         left_gt,
  input  logic                         left_valid,
  input  logic signed [VALUE_BITS-1:0] left_value,
  input  logic                         right_valid,
  input  logic signed [VALUE_BITS-1:0] right_value,
  output logic                         valid_o,
  output logic signed [VALUE_BITS-1:0] value_o,
  output logic                         gt_o
);

  logic                         valid_r, valid_nxt;
  logic signed [VALUE_BITS-1:0] value_r, value_nxt;

  // new sample belongs at or before this cell (ties go after kept values)
  assign gt_o    = !valid_r || (sample < value_r);
  assign valid_o = valid_r;
  assign value_o = value_r;

  // insert, shift right, drop, or shift left
  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (ctl.ins) begin
      if (!ctl.active) begin
        valid_nxt = 1'b0;
      end else if (gt_o) begin
        if (left_gt) begin
          valid_nxt = left_valid;
          value_nxt = left_value;
        end else begin
          valid_nxt = 1'b1;
          value_nxt = sample;
        end
      end
    end else if (ctl.pop) begin
      valid_nxt = right_valid;
      value_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

>>> hw/rtl/k_smallest_select_core.sv
// An accepted sample is registered into the sorted cell chain; one sample per cycle while collecting.
// After a final item the sequencer enters its drain state; the min(k, n) results then leave
// one per cycle while the output is not stalled, each pop loading the output register and
// shifting the whole chain one cell toward it. Input is held off while a run drains.
// Reset: chain empty, select count 4; no clearing pass, the kept values need no reset.
module k_smallest_select_core
  import ksel_pkg::*;
#(
  parameter int MAX_SELECT = MAX_SELECT_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [SEL_W-1:0] cfg_data
);

  localparam int CntW = (MAX_SELECT > 1) ? $clog2(MAX_SELECT) : 1;

  state_t                       state_r, state_nxt;
  logic [SEL_W-1:0]             select_count_r, select_count_nxt;
  logic [SEL_W-1:0]             k_eff;
  logic [CntW-1:0]              rank_r, rank_nxt;
  logic                         out_valid_r, out_valid_nxt;
  out_item_t                    out_item_r, out_item_nxt;
  logic                         in_fire, out_free, pop;
  logic signed [VALUE_BITS-1:0] key;

  logic                         cell_valid [0:MAX_SELECT];
  logic signed [VALUE_BITS-1:0] cell_value [0:MAX_SELECT];
  logic                         cell_gt    [0:MAX_SELECT-1];

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_COLLECT);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign pop       = (state_r == ST_DRAIN) && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // sample to compare width: sign extend or truncate
  assign key = VALUE_BITS'(in_data.sample);

  // effective select count, clamped to 1..MAX_SELECT
  always_comb begin
    k_eff = select_count_r;
    if (select_count_r == '0) begin
      k_eff = SEL_W'(1);
    end else if (select_count_r > SEL_W'(MAX_SELECT)) begin
      k_eff = SEL_W'(MAX_SELECT);
    end
  end

  // chain end beyond the last cell reads as empty
  assign cell_valid[MAX_SELECT] = 1'b0;
  assign cell_value[MAX_SELECT] = '0;

  // the cell chain
  for (genvar i = 0; i < MAX_SELECT; i++) begin : g_cell
    localparam logic [SEL_W-1:0] CellIdx = SEL_W'(i);
    cell_ctl_t                    ctl;
    logic                         l_gt, l_valid;
    logic signed [VALUE_BITS-1:0] l_value;

    assign ctl.ins    = in_fire;
    assign ctl.pop    = pop;
    assign ctl.active = (CellIdx < k_eff);

    if (i == 0) begin : g_head
      assign l_gt    = 1'b0;
      assign l_valid = 1'b0;
      assign l_value = '0;
    end else begin : g_body
      assign l_gt    = cell_gt[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_value = cell_value[i-1];
    end

    ksel_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .sample     (key),
      .left_gt    (l_gt),
      .left_valid (l_valid),
      .left_value (l_value),
      .right_valid(cell_valid[i+1]),
      .right_value(cell_value[i+1]),
      .valid_o    (cell_valid[i]),
      .value_o    (cell_value[i]),
      .gt_o       (cell_gt[i])
    );
  end

  // sequencer and output register
  always_comb begin
    state_nxt        = state_r;
    select_count_nxt = select_count_r;
    rank_nxt         = rank_r;
    out_valid_nxt    = out_valid_r;
    out_item_nxt     = out_item_r;

    if (cfg_valid && cfg_ready) begin
      select_count_nxt = cfg_data;
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_COLLECT: begin
        if (in_fire && in_data.final_item) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pop) begin
          out_valid_nxt             = 1'b1;
          out_item_nxt.picked_value = 32'(cell_value[0]);
          out_item_nxt.rank         = RANK_W'(rank_r);
          out_item_nxt.end_of_run   = !cell_valid[1];
          rank_nxt                  = rank_r + CntW'(1);
          if (!cell_valid[1]) begin
            state_nxt = ST_COLLECT;
            rank_nxt  = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_COLLECT;
      select_count_r <= SEL_RESET;
      rank_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      select_count_r <= select_count_nxt;
      rank_r         <= rank_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

endmodule

>>> hw/rtl/ksel_checker.sv
// Port-level checks for k_smallest_select_core, attached by bind.
// Depends on ksel_pkg for the payload structs.
module ksel_checker
  import ksel_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input in_item_t         in_data,
  input logic             out_valid,
  input logic             out_ready,
  input out_item_t        out_data,
  input logic             cfg_valid,
  input logic             cfg_ready,
  input logic [SEL_W-1:0] cfg_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a final transfer starts a drain, input is held off
  a_final_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.final_item |=> !in_ready)
    else $error("input accepted right after final item");

  // run continues with the next rank in the following cycle
  a_rank_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.end_of_run |=>
      out_valid && (out_data.rank == $past(out_data.rank) + 6'd1))
    else $error("rank sequence broken");

  // no input while a run is still draining
  a_drain_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.end_of_run |-> !in_ready)
    else $error("input accepted during drain");

endmodule

bind k_smallest_select_core ksel_checker u_ksel_checker (.*);

>>> test/testbench.sv
// Self-checking testbench for k_smallest_select_core: directed table, then random sets.
// Depends on ksel_pkg and the k_smallest_select_core RTL, which uses ksel_cell.
module testbench;
  import ksel_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [SEL_W-1:0] cfg_data = '0;

  // predictor state: sorted store of the smallest samples so far
  logic signed [31:0] kept_vals [MAX_SELECT_DEF];
  int                 kept_n = 0;
  logic [SEL_W-1:0]   sel_reg = SEL_RESET;
  out_item_t          expected_picks [$];

  int  mismatches = 0;
  bit  calm = 1'b0;
  int  hold_asks = 0;
  int  hold_seen = 0;
  int  hold_left = 0;

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_TYPED, ROW_SELECT} row_kind_t;
  typedef struct {
    row_kind_t          kind;
    logic signed [31:0] value;
    bit                 fin;
    logic signed [31:0] want;
  } dir_row_t;

  k_smallest_select_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // run limit
  initial begin
    #2_000_000;
    $display("FAIL k_smallest_select_core");
    $finish;
  end

  function automatic int eff_k(logic [SEL_W-1:0] s);
    if (s == 0) return 1;
    if (s > MAX_SELECT_DEF) return MAX_SELECT_DEF;
    return int'(s);
  endfunction

  // take one accepted sample into the store; on a final item queue the picks when post is set
  task automatic select_update(in_item_t it, bit post);
    int k;
    int last;
    int pos;
    out_item_t r;
    k = eff_k(sel_reg);
    if (kept_n > k) kept_n = k;
    last = -1;
    if (kept_n >= k) begin
      if (!(it.sample >= kept_vals[k-1])) last = k - 1;
    end else begin
      last = kept_n;
      kept_n++;
    end
    if (last >= 0) begin
      pos = last;
      while (pos > 0 && kept_vals[pos-1] > it.sample) begin
        kept_vals[pos] = kept_vals[pos-1];
        pos--;
      end
      kept_vals[pos] = it.sample;
    end
    if (it.final_item) begin
      for (int i = 0; i < kept_n; i++) begin
        r.picked_value = kept_vals[i];
        r.rank         = RANK_W'(i);
        r.end_of_run   = (i == kept_n - 1);
        if (post) expected_picks.push_back(r);
      end
      kept_n = 0;
    end
  endtask

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // offer one sample, with random idling before it, and predict once accepted
  task automatic send_sample(logic signed [31:0] value, bit fin, bit typed,
                             logic signed [31:0] want);
    in_item_t it;
    it.sample = value;
    it.final_item = fin;
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < 14) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (!in_ready);
    select_update(it, !typed);
    if (typed) expected_picks.push_back('{picked_value: want, rank: '0, end_of_run: 1'b1});
  endtask

  // drop valid and wait until every expected result has been taken
  task automatic drain_out();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_picks.size() != 0) @(posedge clk);
  endtask

  // register transfer, after every expected result has been taken
  task automatic write_select_count(logic [SEL_W-1:0] v);
    drain_out();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    sel_reg = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2, 3:    return $signed(32'($urandom_range(0, 16))) - 32'sd8;
      4:       return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
      default: return $signed($urandom);
    endcase
  endfunction

  function automatic logic [SEL_W-1:0] rand_select();
    case ($urandom_range(0, 9))
      0:       return 7'd0;
      1:       return 7'd127;
      2:       return 7'd64;
      3:       return SEL_W'($urandom_range(65, 127));
      4:       return SEL_W'($urandom_range(9, 63));
      default: return SEL_W'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic dir_row_t mk_row(row_kind_t kind, logic signed [31:0] value, bit fin,
                                      logic signed [31:0] want);
    dir_row_t r;
    r.kind = kind;
    r.value = value;
    r.fin = fin;
    r.want = want;
    return r;
  endfunction

  // result ready, with random stalls and a long hold-off on request
  always @(negedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = calm || ($urandom_range(0, 99) >= 14);
    end
  end

  // compare each result transfer with the oldest expected pick
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_picks.size() == 0) begin
        flag_mismatch("unexpected result", out_data.picked_value, '0);
      end else begin
        want = expected_picks.pop_front();
        if (out_data.picked_value !== want.picked_value)
          flag_mismatch("picked_value", out_data.picked_value, want.picked_value);
        if (out_data.rank !== want.rank)
          flag_mismatch("rank", 32'(out_data.rank), 32'(want.rank));
        if (out_data.end_of_run !== want.end_of_run)
          flag_mismatch("end_of_run", 32'(out_data.end_of_run), 32'(want.end_of_run));
      end
    end
  end

  initial begin
    dir_row_t dir_rows [$];
    int rnd_items;
    int set_no;
    int len;
    int mid;

    // reset
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // directed rows: extremes, duplicates, boundary ties, select count limits
    dir_rows = '{
      mk_row(ROW_TYPED,  32'sh7FFF_FFFF, 1'b1, 32'sh7FFF_FFFF),
      mk_row(ROW_TYPED,  32'sh8000_0000, 1'b1, 32'sh8000_0000),
      mk_row(ROW_SAMPLE, 32'sd5,         1'b0, 32'sd0),
      mk_row(ROW_SAMPLE, -32'sd3,        1'b0, 32'sd0),
      mk_row(ROW_SAMPLE, 32'sd5,         1'b0, 32'sd0),
      mk_row(ROW_SAMPLE, 32'sh8000_0000, 1'b0, 32'sd0),
      mk_row(ROW_SAMPLE, 32'sh7FFF_FFFF, 1'b0, 32'sd0),
      mk_row(ROW_SAMPLE, 32'sd0,         1'b1, 32'sd0),
      mk_row(ROW_SELECT, 32'sd0,         1'b0, 32'sd0),
      mk_row(ROW_TYPED,  32'sd42,        1'b1, 32'sd42),
      mk_row(ROW_SAMPLE, 32'sd7,         1'b0, 32'sd0),
      mk_row(ROW_SAMPLE, 32'sd7,         1'b0, 32'sd0),
      mk_row(ROW_SAMPLE, 32'sd2,         1'b1, 32'sd0),
      mk_row(ROW_SELECT, 32'sd2,         1'b0, 32'sd0),
      mk_row(ROW_SAMPLE, 32'sd1,         1'b0, 32'sd0),
      mk_row(ROW_SAMPLE, 32'sd1,         1'b0, 32'sd0),
      mk_row(ROW_SAMPLE, 32'sd1,         1'b1, 32'sd0),
      mk_row(ROW_SELECT, 32'sd127,       1'b0, 32'sd0),
      mk_row(ROW_SAMPLE, 32'sd3,         1'b0, 32'sd0),
      mk_row(ROW_SAMPLE, -32'sd1,        1'b1, 32'sd0),
      mk_row(ROW_SELECT, 32'sd64,        1'b0, 32'sd0),
      mk_row(ROW_SAMPLE, 32'sd10,        1'b0, 32'sd0),
      mk_row(ROW_SAMPLE, 32'sd20,        1'b0, 32'sd0),
      mk_row(ROW_SAMPLE, 32'sd30,        1'b0, 32'sd0),
      mk_row(ROW_SAMPLE, 32'sd40,        1'b0, 32'sd0),
      mk_row(ROW_SELECT, 32'sd2,         1'b0, 32'sd0),
      mk_row(ROW_SAMPLE, 32'sd25,        1'b1, 32'sd0),
      mk_row(ROW_SELECT, 32'sd1,         1'b0, 32'sd0),
      mk_row(ROW_TYPED,  -32'sd7,        1'b1, -32'sd7)
    };
    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_SELECT: write_select_count(dir_rows[i].value[SEL_W-1:0]);
        ROW_TYPED:  send_sample(dir_rows[i].value, dir_rows[i].fin, 1'b1, dir_rows[i].want);
        default:    send_sample(dir_rows[i].value, dir_rows[i].fin, 1'b0, 32'sd0);
      endcase
    end

    // random sets, with occasional select count changes inside a set
    rnd_items = 0;
    set_no = 0;
    while (rnd_items < 396) begin
      calm = (set_no >= 10 && set_no < 18);
      if (set_no == 20) begin
        // long receiver hold-off while a full-size set and the next one are offered
        write_select_count(7'd64);
        hold_asks++;
        len = 70;
      end else begin
        if ($urandom_range(0, 2) == 0) write_select_count(rand_select());
        len = ($urandom_range(0, 11) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      end
      mid = (len > 2 && $urandom_range(0, 7) == 0) ? $urandom_range(1, len - 1) : -1;
      for (int i = 0; i < len; i++) begin
        if (i == mid) write_select_count(rand_select());
        send_sample(rand_value(), i == len - 1, 1'b0, 32'sd0);
        rnd_items++;
      end
      // sender pause until all picks are out
      if (set_no % 9 == 4) drain_out();
      set_no++;
    end

    drain_out();
    repeat (30) @(posedge clk);
    if (mismatches == 0 && expected_picks.size() == 0) begin
      $display("PASS k_smallest_select_core");
    end else begin
      $display("FAIL k_smallest_select_core");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/ksel_pkg.sv
hw/rtl/ksel_cell.sv
hw/rtl/k_smallest_select_core.sv
hw/rtl/ksel_checker.sv
test/testbench.sv
